@@ src/plis_pkg.sv @@
`default_nettype none
package plis_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned POS_W        = 8;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned FPOS_W       = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic                      opcode;
    logic signed [VALUE_W-1:0] item_value;
    logic [POS_W-1:0]          position;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FPOS_W-1:0]   found_position;
  } out_t;

endpackage
`default_nettype wire

@@ src/plis_mem.sv @@
`default_nettype none
module plis_mem #(
  parameter int unsigned DEPTH = plis_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [plis_pkg::VALUE_W-1:0] wdata,
  input  wire logic [AW-1:0]                raddr,
  output logic      [plis_pkg::VALUE_W-1:0] rdata
);

  logic [plis_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/plis_seq.sv @@
`default_nettype none
module plis_seq #(
  parameter int unsigned CAPACITY = plis_pkg::CAPACITY_DEF,
  parameter int unsigned AW       = $clog2(CAPACITY),
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire plis_pkg::in_t                in_data,
  output logic                              res_valid,
  input  wire logic                         res_take,
  output plis_pkg::out_t                    res,
  output logic                              mem_we,
  output logic      [AW-1:0]                mem_waddr,
  output logic      [plis_pkg::VALUE_W-1:0] mem_wdata,
  output logic      [AW-1:0]                mem_raddr,
  input  wire logic [plis_pkg::VALUE_W-1:0] mem_rdata
);

  localparam int unsigned IW = AW + 1;
  localparam int unsigned PW = ((CW > plis_pkg::POS_W) ? CW : plis_pkg::POS_W) + 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SHIFT_RD = 3'd1;
  localparam logic [2:0] S_SHIFT_WR = 3'd2;
  localparam logic [2:0] S_WRITE    = 3'd3;
  localparam logic [2:0] S_SRCH_RD  = 3'd4;
  localparam logic [2:0] S_SRCH_CMP = 3'd5;
  localparam logic [2:0] S_RESULT   = 3'd6;

  logic [2:0]                   state_r, state_nxt;
  logic [AW-1:0]                idx_r, idx_nxt;
  logic [AW-1:0]                tgt_r, tgt_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [plis_pkg::VALUE_W-1:0] key_r, key_nxt;
  plis_pkg::out_t               res_r, res_nxt;

  logic          accept;
  logic          pos_ok;
  logic          full;
  logic [AW-1:0] idx_dn;
  logic [IW-1:0] idx_up;
  logic          key_hit;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESULT);
  assign res       = res_r;

  // 1 <= position <= count + 1
  assign pos_ok = (in_data.position != '0) &&
                  (PW'(in_data.position) <= PW'(count_r) + PW'(1));
  assign full   = (count_r == CW'(CAPACITY));
  assign idx_dn = idx_r - AW'(1);
  assign idx_up = IW'(idx_r) + IW'(1);
  // the one compare unit, reused for every entry of a search
  assign key_hit = (mem_rdata == key_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = mem_rdata;
    mem_raddr = idx_r;
    unique case (state_r)
      S_SHIFT_RD: mem_raddr = idx_dn;
      S_SHIFT_WR: mem_we    = 1'b1;
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = tgt_r;
        mem_wdata = key_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    tgt_nxt   = tgt_r;
    count_nxt = count_r;
    key_nxt   = key_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt = in_data.item_value;
          tgt_nxt = AW'(in_data.position - plis_pkg::POS_W'(1));
          res_nxt.found_position = '0;
          if (in_data.opcode == plis_pkg::OP_INSERT) begin
            priority if (!pos_ok) begin
              res_nxt.status = plis_pkg::ST_INVALID;
              state_nxt      = S_RESULT;
            end else if (full) begin
              res_nxt.status = plis_pkg::ST_FULL;
              state_nxt      = S_RESULT;
            end else begin
              idx_nxt   = count_r[AW-1:0];
              state_nxt = (count_r[AW-1:0] == AW'(in_data.position - plis_pkg::POS_W'(1)))
                          ? S_WRITE : S_SHIFT_RD;
            end
          end else begin
            idx_nxt = '0;
            if (count_r == '0) begin
              res_nxt.status = plis_pkg::ST_NOT_FOUND;
              state_nxt      = S_RESULT;
            end else begin
              state_nxt = S_SRCH_RD;
            end
          end
        end
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: begin
        // entry idx-1 has landed in the read register and is written at idx
        idx_nxt   = idx_dn;
        state_nxt = (idx_dn == tgt_r) ? S_WRITE : S_SHIFT_RD;
      end
      S_WRITE: begin
        count_nxt      = count_r + CW'(1);
        res_nxt.status = plis_pkg::ST_INSERTED;
        state_nxt      = S_RESULT;
      end
      S_SRCH_RD: state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: begin
        priority if (key_hit) begin
          res_nxt.status         = plis_pkg::ST_FOUND;
          res_nxt.found_position = plis_pkg::FPOS_W'(idx_up);
          state_nxt              = S_RESULT;
        end else if (idx_up == IW'(count_r)) begin
          res_nxt.status = plis_pkg::ST_NOT_FOUND;
          state_nxt      = S_RESULT;
        end else begin
          idx_nxt   = idx_up[AW-1:0];
          state_nxt = S_SRCH_RD;
        end
      end
      S_RESULT: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    tgt_r <= tgt_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire

@@ src/positional_list_insert_search.sv @@
`default_nettype none
// Ordered list of up to CAPACITY signed 32-bit values with insert-at-position
// and first-match search, one item at a time. The entries sit in a simple
// dual-port style memory (one write, one registered read per cycle), so each
// entry moved or compared takes a read state, then a write or compare state.
// An insert at p moves the entries from p on up one place, last first, then
// writes the item at p; a search stops at the first match or after the last
// entry; a rejected insert or empty-list search goes straight to the result,
// which then moves to the output register. A new item is taken once the
// previous result has moved to the output register, even if it still waits
// for out_ready. Entries are not cleared at reset; only the entry count is.
module positional_list_insert_search #(
  parameter int unsigned CAPACITY = plis_pkg::CAPACITY_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire plis_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output plis_pkg::out_t      out_data
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                         res_valid;
  logic                         res_take;
  plis_pkg::out_t               res;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [plis_pkg::VALUE_W-1:0] mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic [plis_pkg::VALUE_W-1:0] mem_rdata;

  logic           out_valid_r, out_valid_nxt;
  plis_pkg::out_t out_data_r;

  plis_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  plis_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register: loads when empty or when its beat leaves this cycle
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ src/plis_chk.sv @@
`default_nettype none
module plis_chk (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire plis_pkg::out_t out_data
);

  // a waiting result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == plis_pkg::ST_INSERTED ||
                   out_data.status == plis_pkg::ST_INVALID ||
                   out_data.status == plis_pkg::ST_FULL ||
                   out_data.status == plis_pkg::ST_FOUND ||
                   out_data.status == plis_pkg::ST_NOT_FOUND))
    else $error("undefined status code");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != plis_pkg::ST_FOUND |-> out_data.found_position == '0)
    else $error("position reported without a match");

  a_pos_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == plis_pkg::ST_FOUND |-> out_data.found_position != '0)
    else $error("match reported at position zero");

  // the sequencer is busy in the cycle after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

endmodule

bind positional_list_insert_search plis_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
